/* hdl/tlpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_pkg
// types and constants shared by the tank level pump controller and its
// channel interfaces
// ----------------------------------------------------------------------------
package tlpc_pkg;

  // status codes
  localparam logic [1:0] ST_PUMP_OFF   = 2'd0;
  localparam logic [1:0] ST_PUMP_ON    = 2'd1;
  localparam logic [1:0] ST_CFG_ERROR  = 2'd2;
  localparam logic [1:0] ST_SONAR_ERR  = 2'd3;

  // averaged distance at or above this is a sonar fault
  localparam logic [15:0] SONAR_LIMIT   = 16'd32767;

  // log slot geometry: 288 five-minute slots a day, 12 an hour, 2 bytes a slot
  localparam logic [10:0] SLOTS_PER_DAY  = 11'd288;
  localparam logic [10:0] SLOTS_PER_HOUR = 11'd12;
  // minute / 5 as (minute * 205) >> 10, exact for six-bit minutes
  localparam logic [13:0] DIV5_RECIP     = 14'd205;
  localparam int          DIV5_SHIFT     = 10;

  typedef struct packed {
    logic [15:0] echo_time;
    logic        empty_button;
    logic        onmark_button;
    logic [2:0]  weekday;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
  } sample_t;

  typedef struct packed {
    logic               pump_on;
    logic [1:0]         status;
    logic [15:0]        filtered_distance;
    logic signed [15:0] fill_level;
    logic               log_write;
    logic [11:0]        log_address;
    logic               save_request;
    logic signed [15:0] empty_mark_out;
    logic signed [15:0] on_mark_out;
    logic signed [15:0] peak_level_out;
  } result_t;

endpackage

/* hdl/tlpc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_if
// valid/ready channels for sonar samples and controller results
// ----------------------------------------------------------------------------
interface tlpc_sample_if
  import tlpc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlpc_result_if
  import tlpc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/tank_level_pump_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tank_level_pump_controller
// smooths sonar echo times into a tank level, captures calibration marks,
// tracks the peak level, points at a five-minute log slot and drives the
// pump with hysteresis
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------------------
//  sample   | in  | echo time, empty/on-mark buttons, weekday, hour, minute
//  result   | out | pump, status, distance, level, log slot, save, marks
//
//  one beat in, one beat out; a sample is taken every cycle while the
//  result register is empty or being drained, so throughput is one per cycle
//  the result is registered: the filter, calibration and pump logic run between
//  the sample port and the result register, state updates on acceptance
//  a stalled result blocks the next sample only while it is not taken
//  synchronous reset clears the filter, marks, peak, pump and log pointer
// ----------------------------------------------------------------------------
module tank_level_pump_controller
  import tlpc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  tlpc_sample_if.sink    sample,
  tlpc_result_if.source  result
);

  // controller state
  logic [15:0] avg_distance;
  logic [15:0] empty_mark;
  logic [15:0] on_mark;
  logic [15:0] peak_level;
  logic        pump_running;
  logic [11:0] last_log_address;

  logic [15:0] avg_distance_next;
  logic [15:0] empty_mark_next;
  logic [15:0] on_mark_next;
  logic [15:0] peak_level_next;
  logic        pump_running_next;
  logic [11:0] last_log_address_next;
  result_t     result_next;

  logic        accept;

  // take a beat whenever the result register is free or draining
  assign sample.ready = !result.valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  always_comb begin
    logic [18:0] avg_sum;
    logic [15:0] lvl_bits;
    logic        save;
    logic        log_wr;
    logic [11:0] addr;
    logic [1:0]  status;
    logic [10:0] day_idx;
    logic [13:0] min_prod;
    logic [10:0] slot;

    // avg = (echo + 7*avg) >> 3
    avg_sum = {3'b000, sample.data.echo_time} + ({3'b000, avg_distance} << 3)
              - {3'b000, avg_distance};
    avg_distance_next = avg_sum[18:3];

    // level uses the empty mark held before this beat's buttons
    lvl_bits = empty_mark - avg_distance_next;

    empty_mark_next       = empty_mark;
    on_mark_next          = on_mark;
    peak_level_next       = peak_level;
    pump_running_next     = pump_running;
    last_log_address_next = last_log_address;
    save   = 1'b0;
    log_wr = 1'b0;
    addr   = 12'd0;

    // empty button: a negative mark is rewritten even if bits are equal
    if (sample.data.empty_button &&
        (empty_mark[15] || empty_mark != avg_distance_next)) begin
      empty_mark_next = avg_distance_next;
      peak_level_next = 16'd0;
      save            = 1'b1;
    end

    // on button: positive level that differs from the current on-mark
    if (sample.data.onmark_button && $signed(lvl_bits) > 16'sd0 &&
        lvl_bits != on_mark) begin
      on_mark_next    = lvl_bits;
      peak_level_next = lvl_bits;
      save            = 1'b1;
    end

    // log slot, wrapped to 11 bits and doubled to a 12-bit address; weekday zero wraps like the rest
    day_idx  = {8'd0, sample.data.weekday} - 11'd1;
    min_prod = {8'd0, sample.data.minute_of_hour} * DIV5_RECIP;
    slot     = day_idx * SLOTS_PER_DAY
               + {6'd0, sample.data.hour_of_day} * SLOTS_PER_HOUR
               + {7'd0, min_prod[DIV5_SHIFT +: 4]};

    if (avg_distance_next < SONAR_LIMIT) begin
      if ($signed(peak_level_next) < $signed(lvl_bits)) begin
        peak_level_next = lvl_bits;
        save            = 1'b1;
      end
      addr = {slot, 1'b0};
      if (addr != last_log_address) begin
        log_wr                = 1'b1;
        last_log_address_next = addr;
      end
      if ($signed(on_mark_next) > 16'sd0) begin
        if (pump_running) begin
          // a negative empty mark never stops the pump
          if (!empty_mark_next[15] && empty_mark_next < avg_distance_next) begin
            pump_running_next = 1'b0;
          end
        end else begin
          if ($signed(on_mark_next) < $signed(lvl_bits)) begin
            pump_running_next = 1'b1;
          end
        end
        status = pump_running_next ? ST_PUMP_ON : ST_PUMP_OFF;
      end else begin
        status = ST_CFG_ERROR;
      end
    end else begin
      status = ST_SONAR_ERR;
    end

    result_next.pump_on           = pump_running_next;
    result_next.status            = status;
    result_next.filtered_distance = avg_distance_next;
    result_next.fill_level        = lvl_bits;
    result_next.log_write         = log_wr;
    result_next.log_address       = addr;
    result_next.save_request      = save;
    result_next.empty_mark_out    = empty_mark_next;
    result_next.on_mark_out       = on_mark_next;
    result_next.peak_level_out    = peak_level_next;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_distance     <= '0;
      empty_mark       <= '0;
      on_mark          <= '0;
      peak_level       <= '0;
      pump_running     <= 1'b0;
      last_log_address <= '0;
      result.valid     <= 1'b0;
    end else begin
      if (accept) begin
        avg_distance     <= avg_distance_next;
        empty_mark       <= empty_mark_next;
        on_mark          <= on_mark_next;
        peak_level       <= peak_level_next;
        pump_running     <= pump_running_next;
        last_log_address <= last_log_address_next;
        result.valid     <= 1'b1;
      end else if (result.ready) begin
        result.valid     <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      result.data <= result_next;
    end
  end

  // an accepted sample always shows up as a result beat next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted sample produced no result beat");

  // sonar fault never logs
  a_sonar_no_log: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.status == ST_SONAR_ERR) |->
      (!result.data.log_write && result.data.log_address == 12'd0))
    else $error("log slot reported during sonar fault");

  // pump status codes agree with the pump drive
  a_status_matches_pump: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.data.status == ST_PUMP_ON ||
                      result.data.status == ST_PUMP_OFF)) |->
      (result.data.pump_on == (result.data.status == ST_PUMP_ON)))
    else $error("status disagrees with pump drive");

  // the pump drive in the result is the stored pump state
  a_pump_state_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> (result.data.pump_on == pump_running))
    else $error("result pump drive differs from pump state");

endmodule
